### hdl/csem_pkg.sv
// Package with the shared types and codes of the counting semaphore.
`default_nettype none

package csem_pkg;

  // Field widths of the request and result ports.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INIT_W   = 16;

  // The semaphore count is an 18-bit signed value.
  localparam int unsigned COUNT_W = 18;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 18'sh1FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_WAIT   = 2'd0,
    CMD_SIGNAL = 2'd1,
    CMD_TRY    = 2'd2,
    CMD_CLOSE  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BLOCKED  = 3'd1,
    STAT_TRY_FAIL = 3'd2,
    STAT_CLOSED   = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DRAIN
  } state_e;

  // Queue commands from the controller.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_ctrl_t;

  // Queue status toward the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

### hdl/csem_queue.sv
// Circular wait queue of thread ids held in a synchronous memory.
`default_nettype none

module csem_queue #(
  parameter int unsigned MAX_WAITERS = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire csem_pkg::q_ctrl_t ctrl_i,
  input  wire logic [ID_BITS-1:0] wr_data_i,
  output logic [ID_BITS-1:0]    rd_data_o,
  output csem_pkg::q_stat_t     stat_o
);

  localparam int unsigned AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned NW = $clog2(MAX_WAITERS + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WAITERS - 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(MAX_WAITERS);

  logic [ID_BITS-1:0] mem [MAX_WAITERS];
  logic [ID_BITS-1:0] rd_data_q;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      tail_q, tail_d;
  logic [NW-1:0]      cnt_q, cnt_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else begin
      if (ctrl_i.push) begin
        tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
        cnt_d  = cnt_q + NW'(1);
      end
      if (ctrl_i.pop) begin
        head_d = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
        cnt_d  = cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // The controller never pushes and pops in the same cycle, so a read
  // always sees every earlier write without forwarding.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= wr_data_i;
    end
    if (ctrl_i.pop) begin
      rd_data_q <= mem[head_q];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FULL_CNT);

endmodule

`default_nettype wire

### hdl/counting_semaphore_with_wait_queue_core.sv
// Top level of the counting semaphore: count, command sequencer and result register.
//
// Usage: a request (cmd_i, thread_id_i) is taken at a clock edge where start_i
// is high and busy_o is low. Each result appears on status_o, released_valid_o,
// released_id_o and last_o for exactly one cycle with done_o high; the
// receiver cannot stall it. The user must write the init_count register
// via cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
// A wait, a try-wait, a signal that releases nobody and a close of an empty
// queue give their result in the cycle after the request, and the next
// request may follow at once. A signal that releases a waiter passes
// through the registered read of the waiter memory and the ST_POP state
// before its result. A close with waiters gives one result per waiter on
// consecutive cycles from the ST_DRAIN state, one memory read per cycle,
// and busy_o stays high while the queue drains.
// Reset: the count and init_count go to zero and the queue is empty; the
// waiter memory needs no clearing pass, so the block is ready right away.
`default_nettype none

module counting_semaphore_with_wait_queue_core #(
  parameter int unsigned MAX_WAITERS = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [csem_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [csem_pkg::TID_W-1:0]     thread_id_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [csem_pkg::INIT_W-1:0]    cfg_wdata_i,
  output logic                                done_o,
  output logic [csem_pkg::STATUS_W-1:0]       status_o,
  output logic                                released_valid_o,
  output logic [csem_pkg::TID_W-1:0]          released_id_o,
  output logic                                last_o
);

  localparam int unsigned CW = csem_pkg::COUNT_W;

  csem_pkg::state_e  state_q, state_d;
  csem_pkg::q_ctrl_t q_ctrl;
  csem_pkg::q_stat_t q_stat;
  csem_pkg::cmd_e    cmd;

  logic [ID_BITS-1:0]            rd_data;
  logic [csem_pkg::INIT_W-1:0]   init_q;
  logic signed [CW-1:0]          count_q, count_d;
  logic                          accept;
  logic                          count_le0;
  logic                          count_sat;
  logic                          release_now;

  logic                          done_q, done_d;
  logic [csem_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          rvalid_q, rvalid_d;
  logic [csem_pkg::TID_W-1:0]    rid_q, rid_d;
  logic                          last_q, last_d;

  assign cmd       = csem_pkg::cmd_e'(cmd_i);
  assign accept    = start_i && (state_q == csem_pkg::ST_IDLE);
  assign count_le0 = count_q[CW-1] || (count_q == '0);
  assign count_sat = (count_q == csem_pkg::COUNT_MAX);
  // After the increment the count stays at or below zero only if it was negative.
  assign release_now = !count_sat && count_q[CW-1] && !q_stat.empty;

  csem_queue #(
    .MAX_WAITERS (MAX_WAITERS),
    .ID_BITS     (ID_BITS)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (q_ctrl),
    .wr_data_i (ID_BITS'(thread_id_i)),
    .rd_data_o (rd_data),
    .stat_o    (q_stat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csem_pkg::ST_IDLE: begin
        if (accept && cmd == csem_pkg::CMD_SIGNAL && release_now) begin
          state_d = csem_pkg::ST_POP;
        end else if (accept && cmd == csem_pkg::CMD_CLOSE && !q_stat.empty) begin
          state_d = csem_pkg::ST_DRAIN;
        end
      end
      csem_pkg::ST_POP: begin
        state_d = csem_pkg::ST_IDLE;
      end
      csem_pkg::ST_DRAIN: begin
        if (q_stat.empty) begin
          state_d = csem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csem_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    q_ctrl   = '0;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = csem_pkg::STAT_OK;
    rvalid_d = 1'b0;
    rid_d    = '0;
    last_d   = 1'b1;
    unique case (state_q)
      csem_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            csem_pkg::CMD_WAIT: begin
              done_d = 1'b1;
              if (count_le0 && q_stat.full) begin
                status_d = csem_pkg::STAT_FULL;
              end else begin
                count_d = count_q - CW'(1);
                if (count_le0) begin
                  q_ctrl.push = 1'b1;
                  status_d    = csem_pkg::STAT_BLOCKED;
                end
              end
            end
            csem_pkg::CMD_SIGNAL: begin
              if (!count_sat) begin
                count_d = count_q + CW'(1);
              end
              if (release_now) begin
                q_ctrl.pop = 1'b1;
              end else begin
                done_d = 1'b1;
              end
            end
            csem_pkg::CMD_TRY: begin
              done_d = 1'b1;
              if (count_le0) begin
                status_d = csem_pkg::STAT_TRY_FAIL;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            csem_pkg::CMD_CLOSE: begin
              if (q_stat.empty) begin
                done_d       = 1'b1;
                q_ctrl.clear = 1'b1;
                count_d      = CW'(init_q);
              end else begin
                q_ctrl.pop = 1'b1;
              end
            end
            default: begin
              done_d = 1'b0;
            end
          endcase
        end
      end
      csem_pkg::ST_POP: begin
        done_d   = 1'b1;
        rvalid_d = 1'b1;
        rid_d    = csem_pkg::TID_W'(rd_data);
      end
      csem_pkg::ST_DRAIN: begin
        // The pop behind this result has already left the queue, so an empty
        // queue marks the final release.
        done_d   = 1'b1;
        status_d = csem_pkg::STAT_CLOSED;
        rvalid_d = 1'b1;
        rid_d    = csem_pkg::TID_W'(rd_data);
        last_d   = q_stat.empty;
        if (q_stat.empty) begin
          q_ctrl.clear = 1'b1;
          count_d      = CW'(init_q);
        end else begin
          q_ctrl.pop = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csem_pkg::ST_IDLE;
      count_q <= '0;
      init_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rvalid_q <= rvalid_d;
    rid_q    <= rid_d;
    last_q   <= last_d;
  end

  assign busy_o           = (state_q != csem_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign released_valid_o = rvalid_q;
  assign released_id_o    = rid_q;
  assign last_o           = last_q;

  // A close keeps releasing on consecutive cycles until its final result.
  a_drain_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o && status_o == csem_pkg::STAT_CLOSED)
    else $error("close results are not back to back");

  // Only a signal or a close hands out a released id.
  a_release_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && released_valid_o |->
      (status_o == csem_pkg::STAT_OK || status_o == csem_pkg::STAT_CLOSED))
    else $error("released id with a wrong status");

  // Without a release the id field reads zero.
  a_release_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !released_valid_o |-> released_id_o == '0)
    else $error("released id set without release");

  // A try-wait on a count at or below zero fails on the next cycle.
  a_try_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == csem_pkg::CMD_TRY && count_le0 |=>
      done_o && status_o == csem_pkg::STAT_TRY_FAIL)
    else $error("try-wait did not fail");

endmodule

`default_nettype wire
